FILE: src/jsu_pkg.sv
package jsu_pkg;

    // Result kinds (carried on tuser)
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_UNTERMINATED = 3'd0;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd1;
    localparam logic [2:0] ERR_UNPAIRED_HI  = 3'd2;
    localparam logic [2:0] ERR_BAD_LOW      = 3'd3;
    localparam logic [2:0] ERR_LONE_LOW     = 3'd4;
    localparam logic [2:0] ERR_BAD_ESCAPE   = 3'd5;
    localparam logic [2:0] ERR_BAD_HEX      = 3'd6;

    // Queue between decoder and serializer
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Results caused by one input beat: data bytes first, then an optional
    // done or error result
    typedef struct packed {
        logic [2:0]      data_cnt;
        logic [3:0][7:0] data;
        logic            ctl_en;
        logic [1:0]      ctl_kind;
        logic [2:0]      ctl_code;
    } jsu_rec_t;

    function automatic logic [2:0] rec_total(input jsu_rec_t r);
        return r.data_cnt + {2'b00, r.ctl_en};
    endfunction

endpackage

FILE: src/json_string_unescape_to_utf8.sv
// An accepted byte's record is written into the record queue and is then loaded into
// the serializer's current-record register, from which its results are offered.
// Throughput: one input byte per cycle while each byte yields at most one result
// and m_tready is high; results leave one per cycle while m_tready is high, so a \u escape
// that yields several UTF-8 bytes holds input back once the four-entry record queue fills.
// Reset: aresetn low at a clock edge returns the decoder to the string body,
// empties the queue and drops any result in flight.
module json_string_unescape_to_utf8 (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // line_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // run_last
);
    import jsu_pkg::*;

    jsu_rec_t push_rec, head_rec;
    logic     push, full, pop, head_valid;

    jsu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (full),
        .q_push   (push),
        .q_rec    (push_rec)
    );

    jsu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_rec   (push_rec),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    jsu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: src/jsu_front.sv
module jsu_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] text_byte
    input  logic             s_tlast,   // line_last
    input  logic             q_full,
    output logic             q_push,
    output jsu_pkg::jsu_rec_t q_rec
);
    import jsu_pkg::*;

    typedef enum logic [3:0] {
        PH_BODY, PH_ESC, PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4,
        PH_WANT_BS, PH_WANT_U, PH_LOW1, PH_LOW2, PH_LOW3, PH_LOW4, PH_DONE
    } phase_t;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;

    phase_t      phase_reg, phase_next, phase_mid;
    logic [15:0] acc_reg, acc_next;
    logic [15:0] held_reg, held_next;
    logic [15:0] acc_shift;
    logic [4:0]  hex_dig;
    logic [20:0] pair_cp;
    logic [20:0] enc_cp;
    logic [2:0]  enc_cnt;
    logic [3:0][7:0] enc_bytes;
    logic        beat;
    jsu_rec_t    rec;

    // Hex digit: bit 4 flags a valid digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    assign s_tready  = !q_full;
    assign beat      = s_tvalid && s_tready;
    assign hex_dig   = hex_value(s_tdata);
    assign acc_shift = {acc_reg[11:0], hex_dig[3:0]};
    assign pair_cp   = 21'h10000 + {1'b0, held_reg[9:0], acc_shift[9:0]};

    // Pick the code point and encode it as UTF-8
    always_comb begin
        if (phase_reg == PH_LOW4) enc_cp = pair_cp;
        else enc_cp = {5'd0, acc_shift};
        enc_bytes = '0;
        if (enc_cp < 21'h80) begin
            enc_cnt      = 3'd1;
            enc_bytes[0] = enc_cp[7:0];
        end else if (enc_cp < 21'h800) begin
            enc_cnt      = 3'd2;
            enc_bytes[0] = {3'b110, enc_cp[10:6]};
            enc_bytes[1] = {2'b10, enc_cp[5:0]};
        end else if (enc_cp < 21'h10000) begin
            enc_cnt      = 3'd3;
            enc_bytes[0] = {4'b1110, enc_cp[15:12]};
            enc_bytes[1] = {2'b10, enc_cp[11:6]};
            enc_bytes[2] = {2'b10, enc_cp[5:0]};
        end else begin
            enc_cnt      = 3'd4;
            enc_bytes[0] = {5'b11110, enc_cp[20:18]};
            enc_bytes[1] = {2'b10, enc_cp[17:12]};
            enc_bytes[2] = {2'b10, enc_cp[11:6]};
            enc_bytes[3] = {2'b10, enc_cp[5:0]};
        end
    end

    // Classify the byte and build its result record
    always_comb begin
        phase_mid = phase_reg;
        acc_next  = acc_reg;
        held_next = held_reg;
        rec       = '0;
        case (phase_reg)
            PH_BODY: begin
                if (s_tdata == CH_QUOTE) begin
                    rec.ctl_en   = 1'b1;
                    rec.ctl_kind = KIND_DONE;
                    phase_mid    = PH_DONE;
                end else if (s_tdata == CH_BSL) begin
                    phase_mid = PH_ESC;
                end else begin
                    rec.data_cnt = 3'd1;
                    rec.data[0]  = s_tdata;
                end
            end
            PH_ESC: begin
                phase_mid    = PH_BODY;
                rec.data_cnt = 3'd1;
                case (s_tdata)
                    8'h6E: rec.data[0] = 8'h0A;
                    8'h74: rec.data[0] = 8'h09;
                    8'h72: rec.data[0] = 8'h0D;
                    8'h62: rec.data[0] = 8'h08;
                    8'h66: rec.data[0] = 8'h0C;
                    8'h2F, CH_QUOTE, CH_BSL: rec.data[0] = s_tdata;
                    CH_U: begin
                        rec.data_cnt = 3'd0;
                        acc_next     = '0;
                        phase_mid    = PH_HEX1;
                    end
                    default: begin
                        rec.data_cnt = 3'd0;
                        rec.ctl_en   = 1'b1;
                        rec.ctl_kind = KIND_ERR;
                        rec.ctl_code = ERR_BAD_ESCAPE;
                        phase_mid    = PH_DONE;
                    end
                endcase
            end
            PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4,
            PH_LOW1, PH_LOW2, PH_LOW3, PH_LOW4: begin
                if (!s_tlast) begin
                    if (!hex_dig[4]) begin
                        rec.ctl_en   = 1'b1;
                        rec.ctl_kind = KIND_ERR;
                        rec.ctl_code = ERR_BAD_HEX;
                        phase_mid    = PH_DONE;
                    end else begin
                        acc_next = acc_shift;
                        case (phase_reg)
                            PH_HEX1: phase_mid = PH_HEX2;
                            PH_HEX2: phase_mid = PH_HEX3;
                            PH_HEX3: phase_mid = PH_HEX4;
                            PH_LOW1: phase_mid = PH_LOW2;
                            PH_LOW2: phase_mid = PH_LOW3;
                            PH_LOW3: phase_mid = PH_LOW4;
                            PH_HEX4: begin
                                if (acc_shift[15:10] == 6'b110110) begin
                                    held_next = acc_shift;
                                    phase_mid = PH_WANT_BS;
                                end else if (acc_shift[15:10] == 6'b110111) begin
                                    rec.ctl_en   = 1'b1;
                                    rec.ctl_kind = KIND_ERR;
                                    rec.ctl_code = ERR_LONE_LOW;
                                    phase_mid    = PH_DONE;
                                end else begin
                                    rec.data_cnt = enc_cnt;
                                    rec.data     = enc_bytes;
                                    phase_mid    = PH_BODY;
                                end
                            end
                            default: begin
                                // last low digit: must land in the low range
                                if (acc_shift[15:10] != 6'b110111) begin
                                    rec.ctl_en   = 1'b1;
                                    rec.ctl_kind = KIND_ERR;
                                    rec.ctl_code = ERR_BAD_LOW;
                                    phase_mid    = PH_DONE;
                                end else begin
                                    rec.data_cnt = enc_cnt;
                                    rec.data     = enc_bytes;
                                    phase_mid    = PH_BODY;
                                end
                            end
                        endcase
                    end
                end
            end
            PH_WANT_BS, PH_WANT_U: begin
                if (!s_tlast) begin
                    if (phase_reg == PH_WANT_BS && s_tdata == CH_BSL) begin
                        phase_mid = PH_WANT_U;
                    end else if (phase_reg == PH_WANT_U && s_tdata == CH_U) begin
                        acc_next  = '0;
                        phase_mid = PH_LOW1;
                    end else begin
                        rec.ctl_en   = 1'b1;
                        rec.ctl_kind = KIND_ERR;
                        rec.ctl_code = ERR_UNPAIRED_HI;
                        phase_mid    = PH_DONE;
                    end
                end
            end
            default: ;
        endcase

        // End of line: report what was left open, then return to reset state
        phase_next = phase_mid;
        if (s_tlast) begin
            case (phase_mid)
                PH_BODY, PH_ESC: begin
                    rec.ctl_en   = 1'b1;
                    rec.ctl_kind = KIND_ERR;
                    rec.ctl_code = ERR_UNTERMINATED;
                end
                PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
                    rec.ctl_en   = 1'b1;
                    rec.ctl_kind = KIND_ERR;
                    rec.ctl_code = ERR_TRUNCATED;
                end
                PH_WANT_BS, PH_WANT_U, PH_LOW1, PH_LOW2, PH_LOW3, PH_LOW4: begin
                    rec.ctl_en   = 1'b1;
                    rec.ctl_kind = KIND_ERR;
                    rec.ctl_code = ERR_UNPAIRED_HI;
                end
                default: ;
            endcase
            phase_next = PH_BODY;
            acc_next   = '0;
            held_next  = '0;
        end
    end

    assign q_push = beat && (rec_total(rec) != 3'd0);
    assign q_rec  = rec;

    // Hold decoder state, advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_BODY;
            acc_reg   <= '0;
            held_reg  <= '0;
        end else if (beat) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
        end
    end

endmodule

FILE: src/jsu_queue.sv
module jsu_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  jsu_pkg::jsu_rec_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output jsu_pkg::jsu_rec_t head_rec
);
    import jsu_pkg::*;

    jsu_rec_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_rec   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        else if (do_pop && !do_push) count_next = count_reg - 1'b1;
    end

    // Store records
    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_rec;
    end

    // Advance pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/jsu_back.sv
module jsu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  jsu_pkg::jsu_rec_t head_rec,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]        m_tuser,   // [1:0] kind
    output logic              m_tlast    // run_last
);
    import jsu_pkg::*;

    jsu_rec_t   cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg;
    logic [2:0] total;
    logic       is_data;
    logic       run_end;
    logic       out_beat;

    assign total    = rec_total(cur_reg);
    assign is_data  = ({1'b0, idx_reg} < cur_reg.data_cnt);
    assign run_end  = ({1'b0, idx_reg} == total - 3'd1);
    assign out_beat = m_tvalid && m_tready;
    assign pop      = head_valid && (!cur_valid_reg || (out_beat && run_end));

    // Select the current result of the record
    assign m_tvalid = cur_valid_reg;
    assign m_tlast  = run_end;
    assign m_tuser  = is_data ? KIND_DATA : cur_reg.ctl_kind;
    assign m_tdata  = is_data ? {8'd0, cur_reg.data[idx_reg]}
                              : {5'd0, cur_reg.ctl_code, 8'd0};

    // Load a record, step through its results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (pop) begin
            cur_valid_reg <= 1'b1;
            idx_reg       <= '0;
        end else if (out_beat) begin
            if (run_end) cur_valid_reg <= 1'b0;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) cur_reg <= head_rec;
    end

endmodule

FILE: src/jsu_checker.sv
module jsu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    import jsu_pkg::*;

    // Nothing leaves in the cycle after a reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A done or error result always closes the run of its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_DATA |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("control result not last of its run");

    // Data beats carry no error code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_DATA |-> m_tdata[15:8] == 8'd0)
        else $error("data beat with error code");

    // A stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result beat changed");

endmodule

bind json_string_unescape_to_utf8 jsu_checker u_jsu_checker (.*);
